// File: hdl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg: shared definitions for the packed palette pixel decoder
// Field widths, register codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // parameter defaults
    localparam int MAX_INDEX_BITS_DEF = 8;
    localparam int WORD_BITS_DEF      = 64;

    // payload field widths
    localparam int KIND_W      = 1;
    localparam int ENTRY_IDX_W = 16;
    localparam int COLOR_W     = 8;
    localparam int PACKED_W    = 64;

    // configuration register widths
    localparam int IDX_BITS_W  = 5;
    localparam int PIX_CNT_W   = 25;
    localparam int PIX_DONE_W  = 24;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 1;

    // index width limits
    localparam logic [IDX_BITS_W-1:0] IDX_BITS_MIN   = 5'd1;
    localparam logic [IDX_BITS_W-1:0] IDX_BITS_MAX   = 5'd16;
    localparam logic [IDX_BITS_W-1:0] IDX_BITS_RESET = 5'd8;

    // pixel count limits
    localparam logic [PIX_CNT_W-1:0] PIX_CNT_MIN   = 25'd1;
    localparam logic [PIX_CNT_W-1:0] PIX_CNT_MAX   = 25'd16777216;
    localparam logic [PIX_CNT_W-1:0] PIX_CNT_RESET = 25'd1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 1'b1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PALETTE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_WORD    = 1'b1;

endpackage

// File: hdl/ppd_if.sv
// ----------------------------------------------------------------------------
// ppd_if: channel interfaces of the packed palette pixel decoder
// Input item channel (palette entries and packed words) and pixel channel.
// ----------------------------------------------------------------------------

// input item channel
interface ppd_item_if import ppd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [COLOR_W-1:0]     entry_red;
    logic [COLOR_W-1:0]     entry_green;
    logic [COLOR_W-1:0]     entry_blue;
    logic [PACKED_W-1:0]    packed_word;

    modport source (
        output valid, kind, entry_index, entry_red, entry_green, entry_blue,
               packed_word,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, entry_red, entry_green, entry_blue,
               packed_word,
        output ready
    );
endinterface

// decoded pixel channel
interface ppd_pixel_if import ppd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic               word_last;
    logic               image_last;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, word_last, image_last,
        input  ready
    );

    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, word_last, image_last,
        output ready
    );
endinterface

// File: hdl/packed_palette_pixel_decoder.sv
// ----------------------------------------------------------------------------
// packed_palette_pixel_decoder: palette indexed pixel unpacker
// Shifts packed indices out of a word, one index per cycle unless pixels stalls,
// looks each one up in the colour table and streams out one RGB pixel per index.
// ----------------------------------------------------------------------------
// Usage
//   items  : valid/ready sink. A palette transaction (kind 0) writes one RGB
//            entry in the cycle it is taken. A word transaction (kind 1)
//            carries floor(WORD_BITS / index_bits) packed indices, bit 0 first.
//   pixels : valid/ready source, one transaction per decoded index, with
//            word_last on the last pixel of a word and image_last on the
//            pixel that completes the image.
//   cfg_we/cfg_index/cfg_data : register writes, to be made only while the block idles; the block does not enforce it.
// Timing
//   A word is loaded into the shift register when it is taken; its indices then
//   go one per cycle, while pixels is not stalled, through the single colour
//   table read port, and each pixel passes the lookup and output registers.
// Reset
//   A clearing pass zeroes all 1 << MAX_INDEX_BITS entries (256 at the default)
//   of the colour table after reset, with items held not ready; index_bits
//   resets to 8, pixel_count to 1.
// Stall
//   While pixels is stalled the output register and a full lookup register hold,
//   and then no new index is shifted out; the next item may be taken once a word is issued.
// ----------------------------------------------------------------------------
module packed_palette_pixel_decoder
    import ppd_pkg::*;
#(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
    parameter int WORD_BITS      = WORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    ppd_item_if.sink               items,
    ppd_pixel_if.source            pixels,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH  = 1 << MAX_INDEX_BITS;
    localparam int BL_W   = $clog2(WORD_BITS + 1);
    localparam int CW     = (BL_W > IDX_BITS_W) ? BL_W : IDX_BITS_W;
    localparam int RGB_W  = 3 * COLOR_W;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

    // control state
    state_t                  state_reg;
    logic [IDX_BITS_W-1:0]   index_bits_reg;
    logic [PIX_CNT_W-1:0]    pixel_count_reg;
    logic [PIX_DONE_W-1:0]   pixels_done_reg;
    logic [WORD_BITS-1:0]    word_reg;
    logic [BL_W-1:0]         bits_left_reg;
    logic [MAX_INDEX_BITS-1:0] clr_addr_reg;

    // lookup stage
    logic                    rd_vld_reg;
    logic                    rd_wlast_reg;
    logic                    rd_ilast_reg;
    logic [RGB_W-1:0]        rd_data_reg;

    // output stage
    logic                    out_vld_reg;
    logic                    out_wlast_reg;
    logic                    out_ilast_reg;
    logic [RGB_W-1:0]        out_rgb_reg;

    // colour table
    logic [RGB_W-1:0]        color_table [DEPTH];

    logic                    out_free;
    logic                    issue;
    logic                    take_item;
    logic                    take_palette;
    logic [MAX_INDEX_BITS-1:0] idx_src;
    logic [MAX_INDEX_BITS-1:0] idx_mask;
    logic [MAX_INDEX_BITS-1:0] rd_addr;
    logic [MAX_INDEX_BITS-1:0] wr_addr;
    logic [CW-1:0]           ib_ext;
    logic [CW-1:0]           rem_bits;
    logic                    img_end;
    logic                    wrd_end;
    logic                    word_fits;
    logic [IDX_BITS_W-1:0]   cfg_ib;
    logic [PIX_CNT_W-1:0]    cfg_pc;

    // low bits of the word feed the table address
    generate
        if (WORD_BITS >= MAX_INDEX_BITS) begin : g_idx_direct
            assign idx_src = word_reg[MAX_INDEX_BITS-1:0];
        end
        else begin : g_idx_pad
            assign idx_src = MAX_INDEX_BITS'(word_reg);
        end
    endgenerate

    // mask index to the configured width
    always_comb
    begin
        for (int k = 0; k < MAX_INDEX_BITS; k++)
        begin
            idx_mask[k] = (CW'(k) < CW'(index_bits_reg));
        end
    end

    assign rd_addr = idx_src & idx_mask;
    assign wr_addr = items.entry_index[MAX_INDEX_BITS-1:0];

    // handshakes
    assign items.ready  = (state_reg == ST_IDLE);
    assign take_item    = items.valid && items.ready;
    assign take_palette = take_item && (items.kind == KIND_PALETTE);
    assign out_free     = !out_vld_reg || pixels.ready;
    assign issue        = (state_reg == ST_RUN) && (!rd_vld_reg || out_free);

    // per-index bookkeeping
    assign ib_ext    = CW'(index_bits_reg);
    assign rem_bits  = CW'(bits_left_reg) - ib_ext;
    assign img_end   = ({1'b0, pixels_done_reg} + PIX_CNT_W'(1)) >= pixel_count_reg;
    assign wrd_end   = img_end || (rem_bits < ib_ext);
    assign word_fits = ib_ext <= CW'(WORD_BITS);

    // register write clamping
    always_comb
    begin
        cfg_ib = cfg_data[IDX_BITS_W-1:0];
        if (cfg_ib < IDX_BITS_MIN)
            cfg_ib = IDX_BITS_MIN;
        else if (cfg_ib > IDX_BITS_MAX)
            cfg_ib = IDX_BITS_MAX;
        cfg_pc = cfg_data[PIX_CNT_W-1:0];
        if (cfg_pc < PIX_CNT_MIN)
            cfg_pc = PIX_CNT_MIN;
        else if (cfg_pc > PIX_CNT_MAX)
            cfg_pc = PIX_CNT_MAX;
    end

    // state machine, counters and pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            index_bits_reg  <= IDX_BITS_RESET;
            pixel_count_reg <= PIX_CNT_RESET;
            pixels_done_reg <= '0;
            bits_left_reg   <= '0;
            clr_addr_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            // configuration
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_INDEX_BITS:  index_bits_reg  <= cfg_ib;
                    REG_PIXEL_COUNT: pixel_count_reg <= cfg_pc;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (&clr_addr_reg)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (take_item && (items.kind == KIND_WORD) && word_fits)
                    begin
                        state_reg     <= ST_RUN;
                        bits_left_reg <= BL_W'(WORD_BITS);
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        bits_left_reg   <= BL_W'(rem_bits);
                        pixels_done_reg <= img_end ? '0 : pixels_done_reg + 1'b1;
                        if (wrd_end)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // lookup stage valid
            if (issue)
                rd_vld_reg <= 1'b1;
            else if (out_free)
                rd_vld_reg <= 1'b0;

            // output stage valid
            if (out_free)
                out_vld_reg <= rd_vld_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take_item)
            word_reg <= items.packed_word[WORD_BITS-1:0];
        else if (issue)
            word_reg <= word_reg >> index_bits_reg;

        if (issue)
        begin
            rd_wlast_reg <= wrd_end;
            rd_ilast_reg <= img_end;
        end

        if (out_free && rd_vld_reg)
        begin
            out_wlast_reg <= rd_wlast_reg;
            out_ilast_reg <= rd_ilast_reg;
            out_rgb_reg   <= rd_data_reg;
        end
    end

    // colour table, one write and one registered read; cleared after reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            color_table[clr_addr_reg] <= '0;
        else if (take_palette)
            color_table[wr_addr] <= {items.entry_red, items.entry_green, items.entry_blue};
        if (issue)
            rd_data_reg <= color_table[rd_addr];
    end

    // pixel channel
    assign pixels.valid       = out_vld_reg;
    assign pixels.pixel_red   = out_rgb_reg[3*COLOR_W-1:2*COLOR_W];
    assign pixels.pixel_green = out_rgb_reg[2*COLOR_W-1:COLOR_W];
    assign pixels.pixel_blue  = out_rgb_reg[COLOR_W-1:0];
    assign pixels.word_last   = out_wlast_reg;
    assign pixels.image_last  = out_ilast_reg;

    // checks
    a_lookup_held: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg && !out_free |=> rd_vld_reg)
        else $error("lookup stage dropped a pixel under stall");

    a_image_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.image_last |-> pixels.word_last)
        else $error("image end without word end");

    a_index_available: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> CW'(bits_left_reg) >= ib_ext)
        else $error("index shifted out past the end of the word");

    a_word_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        issue && wrd_end |=> state_reg == ST_IDLE)
        else $error("unit still busy after the last index of a word");

endmodule
